// File: sv/kufw_pkg.sv
// shared constants, command and status types for the union-find weight block
package kufw_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int WEIGHT_BITS  = 16;

    localparam int VTX_BITS     = 11;
    localparam int WIN_BITS     = 16;
    localparam int SUM_BITS     = 26;
    localparam int RANK_BITS    = 4;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);

    localparam logic [VTX_BITS-1:0]  COUNT_RESET = VTX_BITS'(MAX_VERTICES);
    localparam logic [RANK_BITS-1:0] RANK_MAX    = '1;
    localparam logic [SUM_BITS-1:0]  SUM_MAX     = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic walk;
        logic comp;
        logic phase_b;
        logic join_sets;
        logic out_load;
        logic clear_step;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic bad_in;
        logic at_root;
        logic path_end;
        logic clear_end;
        logic last_item;
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/kufw_if.sv
// valid/ready channel interfaces for edges, results and configuration

interface kufw_edge_if;
    logic                          valid;
    logic                          ready;
    logic [kufw_pkg::VTX_BITS-1:0] vertex_a;
    logic [kufw_pkg::VTX_BITS-1:0] vertex_b;
    logic [kufw_pkg::WIN_BITS-1:0] edge_weight;
    logic                          last_edge;

    modport source (output valid, vertex_a, vertex_b, edge_weight, last_edge, input ready);
    modport sink (input valid, vertex_a, vertex_b, edge_weight, last_edge, output ready);
endinterface

interface kufw_result_if;
    logic                          valid;
    logic                          ready;
    logic                          joined;
    logic [kufw_pkg::SUM_BITS-1:0] total_weight;
    logic                          bad_vertex;
    logic                          done_res;

    modport source (output valid, joined, total_weight, bad_vertex, done_res, input ready);
    modport sink (input valid, joined, total_weight, bad_vertex, done_res, output ready);
endinterface

interface kufw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [kufw_pkg::VTX_BITS-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink (input valid, vertex_count, output ready);
endinterface

// File: sv/kufw_ctrl.sv
// controller state machine sequencing find walks, compression, link and clearing
module kufw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kufw_pkg::dp_status_t status,
    output kufw_pkg::dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_WALK_A = 8'b0000_0100,
        S_COMP_A = 8'b0000_1000,
        S_WALK_B = 8'b0001_0000,
        S_COMP_B = 8'b0010_0000,
        S_JOIN   = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.bad_in ? S_RESULT : S_WALK_A;
                end
            end
            S_WALK_A:
            begin
                cmd.walk = 1'b1;
                if (status.at_root)
                begin
                    state_next = S_COMP_A;
                end
            end
            S_COMP_A:
            begin
                cmd.comp = 1'b1;
                if (status.path_end)
                begin
                    state_next = S_WALK_B;
                end
            end
            S_WALK_B:
            begin
                cmd.walk    = 1'b1;
                cmd.phase_b = 1'b1;
                if (status.at_root)
                begin
                    state_next = S_COMP_B;
                end
            end
            S_COMP_B:
            begin
                cmd.comp    = 1'b1;
                cmd.phase_b = 1'b1;
                if (status.path_end)
                begin
                    state_next = S_JOIN;
                end
            end
            S_JOIN:
            begin
                cmd.join_sets = 1'b1;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.last_item ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: sv/kufw_datapath.sv
// datapath: parent and rank memories, find registers, running total, output register
module kufw_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kufw_pkg::dp_cmd_t                 cmd,
    output kufw_pkg::dp_status_t              status,
    input  logic [kufw_pkg::VTX_BITS-1:0]     vertex_a,
    input  logic [kufw_pkg::VTX_BITS-1:0]     vertex_b,
    input  logic [kufw_pkg::WIN_BITS-1:0]     edge_weight,
    input  logic                              last_edge,
    input  logic                              cfg_valid,
    input  logic [kufw_pkg::VTX_BITS-1:0]     cfg_count,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              joined,
    output logic [kufw_pkg::SUM_BITS-1:0]     total_weight,
    output logic                              bad_vertex,
    output logic                              done_res
);

    localparam int AW = kufw_pkg::ADDR_BITS;
    localparam int VW = kufw_pkg::VTX_BITS;
    localparam int RW = kufw_pkg::RANK_BITS;
    localparam int SW = kufw_pkg::SUM_BITS;
    localparam int WW = kufw_pkg::WEIGHT_BITS;

    // disjoint-set memories
    logic [AW-1:0] parent_mem [kufw_pkg::MAX_VERTICES];
    logic [RW-1:0] rank_mem   [kufw_pkg::MAX_VERTICES];

    logic [AW-1:0] par_rdata_reg;
    logic [RW-1:0] rank_rdata_reg;
    logic          par_ren;
    logic [AW-1:0] par_raddr;
    logic          par_we;
    logic [AW-1:0] par_waddr;
    logic [AW-1:0] par_wdata;
    logic          rank_ren;
    logic          rank_we;
    logic [AW-1:0] rank_waddr;
    logic [RW-1:0] rank_wdata;

    // control registers
    logic [VW-1:0] vertex_count_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic          out_valid_reg;
    logic [AW-1:0] clr_cnt_reg;

    // item registers
    logic [AW-1:0] node_a_reg;
    logic [AW-1:0] node_b_reg;
    logic [AW-1:0] cur_reg;
    logic [AW-1:0] cur_next;
    logic [AW-1:0] root_reg;
    logic [AW-1:0] root_a_reg;
    logic [RW-1:0] rank_a_reg;
    logic [WW-1:0] weight_reg;
    logic          last_reg;
    logic          bad_reg;
    logic          joined_reg;

    // output registers
    logic          out_joined_reg;
    logic [SW-1:0] out_total_reg;
    logic          out_bad_reg;
    logic          out_done_reg;

    logic [VW-1:0] eff_count;
    logic [VW-1:0] a_m1;
    logic [VW-1:0] b_m1;
    logic [AW-1:0] node_in_a;
    logic [AW-1:0] node_in_b;
    logic [AW-1:0] node_sel;
    logic          bad_in;
    logic          at_root;
    logic          path_end;
    logic          roots_differ;
    logic          a_lower;
    logic [SW:0]   sum_wide;

    // range check of the endpoints against the clamped count
    assign eff_count = (vertex_count_reg > VW'(kufw_pkg::MAX_VERTICES)) ?
                       VW'(kufw_pkg::MAX_VERTICES) : vertex_count_reg;
    assign bad_in    = (vertex_a == '0) || (vertex_b == '0) ||
                       (vertex_a > eff_count) || (vertex_b > eff_count);
    assign a_m1      = vertex_a - VW'(1);
    assign b_m1      = vertex_b - VW'(1);
    assign node_in_a = a_m1[AW-1:0];
    assign node_in_b = b_m1[AW-1:0];

    // find status
    assign node_sel     = cmd.phase_b ? node_b_reg : node_a_reg;
    assign at_root      = (par_rdata_reg == cur_reg);
    assign path_end     = (cur_reg == root_reg);
    assign roots_differ = (root_a_reg != root_reg);
    assign a_lower      = (rank_a_reg < rank_rdata_reg);

    // saturating running total
    assign sum_wide = {1'b0, sum_reg} + (SW + 1)'(weight_reg);
    assign sum_next = sum_wide[SW] ? kufw_pkg::SUM_MAX : sum_wide[SW-1:0];

    assign status.bad_in    = bad_in;
    assign status.at_root   = at_root;
    assign status.path_end  = path_end;
    assign status.clear_end = (clr_cnt_reg == '1);
    assign status.last_item = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // parent read address and walk pointer
    always_comb
    begin
        par_ren   = 1'b0;
        par_raddr = cur_reg;
        cur_next  = cur_reg;
        if (cmd.load_item)
        begin
            par_ren   = 1'b1;
            par_raddr = node_in_a;
            cur_next  = node_in_a;
        end
        else if (cmd.walk)
        begin
            par_ren = 1'b1;
            if (at_root)
            begin
                par_raddr = node_sel;
                cur_next  = node_sel;
            end
            else
            begin
                par_raddr = par_rdata_reg;
                cur_next  = par_rdata_reg;
            end
        end
        else if (cmd.comp && !path_end)
        begin
            par_ren   = 1'b1;
            par_raddr = par_rdata_reg;
            cur_next  = par_rdata_reg;
        end
        else if (cmd.comp && !cmd.phase_b)
        begin
            par_ren   = 1'b1;
            par_raddr = node_b_reg;
            cur_next  = node_b_reg;
        end
    end

    // memory writes: clearing pass, path compression, link by rank
    always_comb
    begin
        par_we     = 1'b0;
        par_waddr  = cur_reg;
        par_wdata  = root_reg;
        rank_we    = 1'b0;
        rank_waddr = root_a_reg;
        rank_wdata = rank_a_reg + RW'(1);
        if (cmd.clear_step)
        begin
            par_we     = 1'b1;
            par_waddr  = clr_cnt_reg;
            par_wdata  = clr_cnt_reg;
            rank_we    = 1'b1;
            rank_waddr = clr_cnt_reg;
            rank_wdata = '0;
        end
        else if (cmd.comp && !path_end)
        begin
            par_we = 1'b1;
        end
        else if (cmd.join_sets && roots_differ)
        begin
            par_we = 1'b1;
            if (a_lower)
            begin
                par_waddr = root_a_reg;
                par_wdata = root_reg;
            end
            else
            begin
                par_waddr = root_reg;
                par_wdata = root_a_reg;
                rank_we   = (rank_a_reg == rank_rdata_reg) &&
                            (rank_a_reg != kufw_pkg::RANK_MAX);
            end
        end
    end

    assign rank_ren = cmd.walk && at_root;

    // parent memory
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        if (par_ren)
        begin
            par_rdata_reg <= parent_mem[par_raddr];
        end
    end

    // rank memory
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (rank_ren)
        begin
            rank_rdata_reg <= rank_mem[cur_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= kufw_pkg::COUNT_RESET;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
            clr_cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vertex_count_reg <= cfg_count;
            end
            if (cmd.join_sets && roots_differ)
            begin
                sum_reg <= sum_next;
            end
            else if (cmd.out_load && last_reg)
            begin
                sum_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // item and find registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.load_item)
        begin
            node_a_reg <= node_in_a;
            node_b_reg <= node_in_b;
            weight_reg <= edge_weight[WW-1:0];
            last_reg   <= last_edge;
            bad_reg    <= bad_in;
            joined_reg <= 1'b0;
        end
        if (cmd.walk && at_root)
        begin
            root_reg <= cur_reg;
        end
        if (cmd.comp && path_end && !cmd.phase_b)
        begin
            root_a_reg <= root_reg;
            rank_a_reg <= rank_rdata_reg;
        end
        if (cmd.join_sets)
        begin
            joined_reg <= roots_differ;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_joined_reg <= joined_reg;
            out_total_reg  <= sum_reg;
            out_bad_reg    <= bad_reg;
            out_done_reg   <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign joined       = out_joined_reg;
    assign total_weight = out_total_reg;
    assign bad_vertex   = out_bad_reg;
    assign done_res     = out_done_reg;

endmodule

// File: sv/kruskal_union_find_weight.sv
// top level: spanning tree weight over a union-find store
// an edge with a bad endpoint skips both find walks and goes straight to the result;
// each of the two find walks takes at most 10 hops by rank
// one edge at a time: a new edge is taken only after the last result is loaded;
// each find hop and compression step uses the single-read, single-write parent memory port
// reset and each last edge start a clearing pass over all 1024 entries, no edge taken
module kruskal_union_find_weight (
    input  logic                 clk,
    input  logic                 rst_n,
    kufw_edge_if.sink            edges,
    kufw_result_if.source        results,
    kufw_cfg_if.sink             cfg
);

    kufw_pkg::dp_cmd_t    cmd;
    kufw_pkg::dp_status_t status;
    logic                 in_ready;

    assign edges.ready = in_ready;
    assign cfg.ready   = 1'b1;

    // controller
    kufw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    kufw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .vertex_a     (edges.vertex_a),
        .vertex_b     (edges.vertex_b),
        .edge_weight  (edges.edge_weight),
        .last_edge    (edges.last_edge),
        .cfg_valid    (cfg.valid),
        .cfg_count    (cfg.vertex_count),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .joined       (results.joined),
        .total_weight (results.total_weight),
        .bad_vertex   (results.bad_vertex),
        .done_res     (results.done_res)
    );

endmodule
